// ===== hdl/qte_pkg.sv =====
// Shared constants, the CORDIC arctangent table and the angle rounding function
// for the quaternion to Euler angle converter. Depends on nothing.
`default_nettype none

package qte_pkg;

  // Number of CORDIC iterations per unit, default for the top-level parameter.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;

  // Datapath width of the CORDIC vectors (matrix terms are Q.30, up to 34 bits).
  localparam int CW = 38;
  // Width of the angle accumulator (Q.20 radians).
  localparam int ZW = 24;
  // Width of the output angles and of the quaternion components.
  localparam int AW = 16;
  localparam int QW = 16;
  localparam int THR_W = 15;

  localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1 <<< 30);
  localparam logic signed [ZW-1:0] PI_Q20 = ZW'(3294199);
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic signed [ZW-1:0] ANGLE_MAX = ZW'(25736);
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(64);

  // atan(2^-i) in Q.20, rounded to nearest; zero from i = 21 on.
  localparam logic signed [ZW-1:0] ATAN_TAB [0:CORDIC_STEPS_MAX-1] = '{
    ZW'(823550), ZW'(486170), ZW'(256879), ZW'(130396),
    ZW'(65451),  ZW'(32757),  ZW'(16383),  ZW'(8192),
    ZW'(4096),   ZW'(2048),   ZW'(1024),   ZW'(512),
    ZW'(256),    ZW'(128),    ZW'(64),     ZW'(32),
    ZW'(16),     ZW'(8),      ZW'(4),      ZW'(2),
    ZW'(1),      ZW'(0),      ZW'(0),      ZW'(0)
  };

  // Q.20 angle to Q3.13 with round half up, saturated to plus or minus ANGLE_MAX.
  function automatic logic signed [AW-1:0] to_q13(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    r = (z + ROUND_HALF) >>> 7;
    if (r > ANGLE_MAX) begin
      r = ANGLE_MAX;
    end else if (r < -ANGLE_MAX) begin
      r = -ANGLE_MAX;
    end
    return r[AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/qte_cordic.sv =====
// Pipelined CORDIC vectoring unit: one register stage for the half-plane fold
// and one per iteration, with a sideband carried alongside. Uses qte_pkg.
`default_nettype none

module qte_cordic #(
  parameter int STEPS  = qte_pkg::CORDIC_STEPS_DEF,
  parameter int SIDE_W = 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_valid,
  input  wire logic signed [qte_pkg::CW-1:0] in_x,
  input  wire logic signed [qte_pkg::CW-1:0] in_y,
  input  wire logic [SIDE_W-1:0]       in_side,
  output logic                         out_valid,
  output logic signed [qte_pkg::CW-1:0] out_mag,
  output logic signed [qte_pkg::ZW-1:0] out_angle,
  output logic                         out_zero,
  output logic [SIDE_W-1:0]            out_side
);

  logic                          v_r    [0:STEPS];
  logic signed [qte_pkg::CW-1:0] x_r    [0:STEPS];
  logic signed [qte_pkg::CW-1:0] y_r    [0:STEPS];
  logic signed [qte_pkg::ZW-1:0] z_r    [0:STEPS];
  logic                          zero_r [0:STEPS];
  logic [SIDE_W-1:0]             side_r [0:STEPS];

  logic                          flip;
  logic signed [qte_pkg::ZW-1:0] z_init;

  // A vector in the left half-plane is turned by pi before the iterations.
  assign flip   = in_x[qte_pkg::CW-1];
  assign z_init = !flip ? '0 : (in_y[qte_pkg::CW-1] ? -qte_pkg::PI_Q20 : qte_pkg::PI_Q20);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= flip ? -in_x : in_x;
      y_r[0]    <= flip ? -in_y : in_y;
      z_r[0]    <= z_init;
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [qte_pkg::CW-1:0] dx;
    logic signed [qte_pkg::CW-1:0] dy;
    logic                          up;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign up = !y_r[i][qte_pkg::CW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= up ? x_r[i] + dx : x_r[i] - dx;
        y_r[i+1]    <= up ? y_r[i] - dy : y_r[i] + dy;
        z_r[i+1]    <= up ? z_r[i] + qte_pkg::ATAN_TAB[i] : z_r[i] - qte_pkg::ATAN_TAB[i];
        zero_r[i+1] <= zero_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_mag   = x_r[STEPS];
  assign out_angle = z_r[STEPS];
  assign out_zero  = zero_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

`default_nettype wire

// ===== hdl/quaternion_to_euler.sv =====
// Top level of the quaternion to Euler angle converter: matrix terms, the
// magnitude CORDIC and the two angle CORDICs. Uses qte_pkg and qte_cordic.
//
//   channel   signals                                        direction
//   in        in_valid, in_stall, in_qx/qy/qz/qw             item in
//   out       out_valid, out_stall, out_angle_x/y/z, out_gimbal_locked  result out
//   cfg       cfg_valid, cfg_ready, cfg_gimbal_threshold     register write
//
// One quaternion is taken in every cycle while in_stall is low; the latency is set
// by the two CORDIC chains that run one after the other.
// Reset empties the pipeline and clears the threshold to zero.
// A stall on the result side holds the whole pipeline, so in_stall follows it
// whenever the output register is full.
`default_nettype none

module quaternion_to_euler #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire logic signed [qte_pkg::QW-1:0] in_qx,
  input  wire logic signed [qte_pkg::QW-1:0] in_qy,
  input  wire logic signed [qte_pkg::QW-1:0] in_qz,
  input  wire logic signed [qte_pkg::QW-1:0] in_qw,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [qte_pkg::AW-1:0]     out_angle_x,
  output logic signed [qte_pkg::AW-1:0]     out_angle_y,
  output logic signed [qte_pkg::AW-1:0]     out_angle_z,
  output logic                              out_gimbal_locked,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [qte_pkg::THR_W-1:0]    cfg_gimbal_threshold
);

  localparam int CW = qte_pkg::CW;
  localparam int ZW = qte_pkg::ZW;
  localparam int AW = qte_pkg::AW;
  localparam int QW = qte_pkg::QW;
  localparam int PW = CW + 15;

  logic                        advance;
  logic [qte_pkg::THR_W-1:0]   thr_r;

  // Stage a: first products.
  logic                        va_r;
  logic signed [2*QW-1:0]      p_xz_r, p_yw_r, p_xx_r, p_yy_r;
  logic [4*QW-1:0]             q_a_r;

  // Magnitude CORDIC.
  logic signed [CW-1:0]        m31, m33;
  logic                        av;
  logic signed [CW-1:0]        a_mag;
  logic signed [ZW-1:0]        a_ang;
  logic                        a_zero;
  logic [4*QW-1:0]             a_side;
  logic signed [QW-1:0]        cx, cy_c, cz, cw_c;

  // Stage c: gain correction and the remaining products.
  logic                        vc_r;
  logic [PW-1:0]               prod_r;
  logic signed [AW-1:0]        ay_r;
  logic signed [2*QW-1:0]      c_xy_r, c_yz_r, c_xw_r, c_zw_r, c_xx_r, c_yy_r, c_zz_r;

  // Stage d: branch choice and inputs to the angle CORDICs.
  logic [CW-2:0]               cy_q30;
  logic [CW-17:0]              cy_q15;
  logic                        locked;
  logic signed [CW-1:0]        neg_m32, m12, m22, m11, neg_m21;
  logic signed [CW-1:0]        zx_in, zy_in;

  logic                        xv;
  logic signed [CW-1:0]        x_mag;
  logic signed [ZW-1:0]        x_ang;
  logic                        x_zero;
  logic [AW-1:0]               x_side;
  logic                        zv;
  logic signed [CW-1:0]        z_mag;
  logic signed [ZW-1:0]        z_ang;
  logic                        z_zero;
  logic                        z_side;

  // Output register.
  logic                        out_valid_r;
  logic signed [AW-1:0]        out_angle_x_r, out_angle_y_r, out_angle_z_r;
  logic                        out_locked_r;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_gimbal_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vc_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      va_r <= in_valid;
      vc_r <= av;
      out_valid_r <= xv;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_xz_r <= in_qx * in_qz;
      p_yw_r <= in_qy * in_qw;
      p_xx_r <= in_qx * in_qx;
      p_yy_r <= in_qy * in_qy;
      q_a_r  <= {in_qx, in_qy, in_qz, in_qw};
    end
  end

  assign m31 = (CW'(p_xz_r) + CW'(p_yw_r)) <<< 1;
  assign m33 = qte_pkg::ONE_Q30 - ((CW'(p_xx_r) + CW'(p_yy_r)) <<< 1);

  qte_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(4*QW)) u_cordic_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (va_r),
    .in_x      (m33),
    .in_y      (m31),
    .in_side   (q_a_r),
    .out_valid (av),
    .out_mag   (a_mag),
    .out_angle (a_ang),
    .out_zero  (a_zero),
    .out_side  (a_side)
  );

  assign cx   = a_side[4*QW-1:3*QW];
  assign cy_c = a_side[3*QW-1:2*QW];
  assign cz   = a_side[2*QW-1:QW];
  assign cw_c = a_side[QW-1:0];

  // The magnitude is never negative, so its sign bit is dropped before scaling.
  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r <= PW'(a_mag[CW-2:0] * qte_pkg::INV_GAIN_Q16);
      ay_r   <= qte_pkg::to_q13(a_zero ? '0 : a_ang);
      c_xy_r <= cx * cy_c;
      c_yz_r <= cy_c * cz;
      c_xw_r <= cx * cw_c;
      c_zw_r <= cz * cw_c;
      c_xx_r <= cx * cx;
      c_yy_r <= cy_c * cy_c;
      c_zz_r <= cz * cz;
    end
  end

  assign cy_q30  = prod_r[PW-1:16];
  assign cy_q15  = prod_r[PW-1:31];
  assign locked  = !(cy_q15 > (CW-16)'(thr_r));

  assign neg_m32 = (CW'(c_xw_r) - CW'(c_yz_r)) <<< 1;
  assign m12     = (CW'(c_xy_r) + CW'(c_zw_r)) <<< 1;
  assign m22     = qte_pkg::ONE_Q30 - ((CW'(c_xx_r) + CW'(c_zz_r)) <<< 1);
  assign m11     = qte_pkg::ONE_Q30 - ((CW'(c_yy_r) + CW'(c_zz_r)) <<< 1);
  assign neg_m21 = (CW'(c_zw_r) - CW'(c_xy_r)) <<< 1;

  assign zx_in = locked ? m11 : m22;
  assign zy_in = locked ? neg_m21 : m12;

  qte_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(AW)) u_cordic_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (vc_r),
    .in_x      ({1'b0, cy_q30}),
    .in_y      (neg_m32),
    .in_side   (ay_r),
    .out_valid (xv),
    .out_mag   (x_mag),
    .out_angle (x_ang),
    .out_zero  (x_zero),
    .out_side  (x_side)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(1)) u_cordic_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (vc_r),
    .in_x      (zx_in),
    .in_y      (zy_in),
    .in_side   (locked),
    .out_valid (zv),
    .out_mag   (z_mag),
    .out_angle (z_ang),
    .out_zero  (z_zero),
    .out_side  (z_side)
  );

  // Both angle units run in lockstep. Under gimbal lock the y angle is zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_angle_x_r <= qte_pkg::to_q13(x_zero ? '0 : x_ang);
      out_angle_y_r <= z_side ? '0 : x_side;
      out_angle_z_r <= qte_pkg::to_q13(z_zero ? '0 : z_ang);
      out_locked_r  <= z_side;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_angle_x       = out_angle_x_r;
  assign out_angle_y       = out_angle_y_r;
  assign out_angle_z       = out_angle_z_r;
  assign out_gimbal_locked = out_locked_r;

endmodule

`default_nettype wire

// ===== test/quaternion_to_euler_check.sv =====
// Checker for the quaternion to Euler angle converter: watches the input, result
// and threshold write channels, predicts each result and compares. Depends on qte_pkg.
`default_nettype none

module quaternion_to_euler_check (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  wire logic signed [qte_pkg::QW-1:0] in_qx,
  input  wire logic signed [qte_pkg::QW-1:0] in_qy,
  input  wire logic signed [qte_pkg::QW-1:0] in_qz,
  input  wire logic signed [qte_pkg::QW-1:0] in_qw,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire logic signed [qte_pkg::AW-1:0] out_angle_x,
  input  wire logic signed [qte_pkg::AW-1:0] out_angle_y,
  input  wire logic signed [qte_pkg::AW-1:0] out_angle_z,
  input  wire                                out_gimbal_locked,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready,
  input  wire logic [qte_pkg::THR_W-1:0]     cfg_gimbal_threshold,
  output int                                 fail_count,
  output int                                 pending_angles
);

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               locked;
  } euler_t;

  localparam int STEPS = 16;
  localparam longint PI_Q20 = 3294199;
  localparam longint ONE = longint'(1) << 30;
  localparam longint LIM = 25736;

  longint atan_q20 [0:23] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
    8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  logic [14:0] lock_limit;
  euler_t angles_due [$];

  // Vectoring rotation: returns the angle in Q.20, the scaled length in len.
  function automatic longint vector_angle(input longint vx, input longint vy,
                                          output longint len);
    longint acc, sx, sy;
    acc = 0;
    if (vx < 0) begin
      acc = (vy >= 0) ? PI_Q20 : -PI_Q20;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = vy >>> i;
      sy = vx >>> i;
      if (vy >= 0) begin
        vx += sx; vy -= sy; acc += atan_q20[i];
      end else begin
        vx -= sx; vy += sy; acc -= atan_q20[i];
      end
    end
    len = vx;
    return acc;
  endfunction

  function automatic longint heading(input longint vy, input longint vx);
    longint unused;
    if (vx == 0 && vy == 0) return 0;
    return vector_angle(vx, vy, unused);
  endfunction

  function automatic logic signed [15:0] radians_q13(input longint a);
    longint r;
    r = (a + 64) >>> 7;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[15:0];
  endfunction

  function automatic euler_t predict_euler(input longint x, input longint y,
                                           input longint z, input longint w);
    longint m31, m32, m33, len, cy30, cy15, a;
    euler_t e;
    m31 = 2 * (x * z + y * w);
    m32 = 2 * (y * z - x * w);
    m33 = ONE - 2 * (x * x + y * y);
    len = 0;
    if (m31 != 0 || m33 != 0) a = vector_angle(m33, m31, len);
    cy30 = (len * 39797) >>> 16;
    cy15 = (len * 39797) >>> 31;
    e.ax = radians_q13(heading(-m32, cy30));
    e.locked = !(cy15 > longint'(lock_limit));
    if (!e.locked) begin
      e.ay = radians_q13(heading(m31, m33));
      e.az = radians_q13(heading(2 * (x * y + z * w), ONE - 2 * (x * x + z * z)));
    end else begin
      e.ay = 0;
      e.az = radians_q13(heading(-2 * (x * y - z * w), ONE - 2 * (y * y + z * z)));
    end
    return e;
  endfunction

  assign pending_angles = angles_due.size();

  always @(posedge clk) begin
    euler_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      lock_limit <= '0;
      fail_count <= 0;
      angles_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (angles_due.size() == 0) begin
          $error("unexpected result transfer");
          errs++;
        end else begin
          e = angles_due.pop_front();
          if (out_angle_x !== e.ax) begin
            $error("angle_x expected %0d actual %0d", e.ax, out_angle_x);
            errs++;
          end
          if (out_angle_y !== e.ay) begin
            $error("angle_y expected %0d actual %0d", e.ay, out_angle_y);
            errs++;
          end
          if (out_angle_z !== e.az) begin
            $error("angle_z expected %0d actual %0d", e.az, out_angle_z);
            errs++;
          end
          if (out_gimbal_locked !== e.locked) begin
            $error("gimbal_locked expected %0d actual %0d", e.locked, out_gimbal_locked);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      // Prediction uses the threshold in force before a write at this edge.
      if (in_valid && !in_stall)
        angles_due.push_back(predict_euler(in_qx, in_qy, in_qz, in_qw));
      if (cfg_valid && cfg_ready) lock_limit <= cfg_gimbal_threshold;
    end
  end

endmodule

`default_nettype wire

// ===== test/quaternion_to_euler_test.sv =====
// Testbench top for the quaternion to Euler angle converter: drives quaternions
// and threshold writes, and gives the verdict. Uses quaternion_to_euler_check.
`default_nettype none

module quaternion_to_euler_test;

  localparam int LATENCY = 2 * 16 + 5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [15:0] in_qx = '0, in_qy = '0, in_qz = '0, in_qw = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [14:0] cfg_gimbal_threshold = '0;
  wire in_stall, out_valid, out_gimbal_locked, cfg_ready;
  wire signed [15:0] out_angle_x, out_angle_y, out_angle_z;
  int fail_count, pending_angles;
  int send_idle_pct, stall_pct;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  quaternion_to_euler u_dut (.*);

  quaternion_to_euler_check u_check (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_quat(input logic [15:0] x, y, z, w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_qx <= x; in_qy <= y; in_qz <= z; in_qw <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_angles != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [14:0] v);
    cfg_valid <= 1'b1;
    cfg_gimbal_threshold <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly near-unit quaternions, sometimes close to gimbal lock, some raw.
  task automatic send_random_quat();
    int s, c, k;
    k = $urandom_range(9);
    if (k < 2) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (k < 4) begin
      s = $urandom_range(23170) + $urandom_range(40) - 20;
      c = 23170 - $urandom_range(60);
      if ($urandom_range(1))
        send_quat(16'(s), 16'($urandom_range(1) ? c : -c), 16'd0, 16'($urandom_range(200)));
      else
        send_quat(16'($urandom_range(300)), 16'(c), 16'($urandom_range(300)),
                  16'($urandom_range(1) ? s : -s));
    end else begin
      s = $urandom_range(16384) - 8192;
      c = $urandom_range(16384) - 8192;
      k = $urandom_range(16384) - 8192;
      send_quat(16'(s), 16'(c), 16'(k),
                16'(($urandom_range(1) ? 1 : -1) * (32767 - (s*s + c*c + k*k) / 65536)));
    end
  endtask

  initial begin
    logic [14:0] limits [0:3];
    limits = '{15'd0, 15'h7fff, 15'd2000, 15'd200};
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_threshold(15'd0);
    send_quat(0, 0, 0, 16'sh7fff);
    send_quat(0, 0, 0, 0);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh7fff, 0, 0, 0);
    send_quat(0, 16'sh7fff, 0, 0);
    send_quat(0, 0, 16'sh7fff, 0);
    send_quat(0, 23170, 0, 23170);
    send_quat(0, -23170, 0, 23170);
    send_quat(23170, 0, 0, 23170);
    send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_quat(16'shffff, 1, 16'shffff, 1);
    drain_results();
    write_threshold(15'h7fff);
    send_quat(0, 0, 0, 16'sh7fff);
    send_quat(0, 23170, 0, 23170);
    send_quat(16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000);
    drain_results();
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(ph == 0 ? limits[ph] : 15'($urandom_range(4000)));
      if (ph == 3) write_threshold(limits[1] - 15'($urandom_range(1)));
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      for (int n = 0; n < 300; n++) begin
        send_random_quat();
        if (n == 150) begin
          // Hold off until the pipeline has emptied.
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_angles != 0) @(posedge clk);
        end
      end
      drain_results();
    end
    stall_pct = 0;
    drain_results();
    if (fail_count == 0) $display("quaternion_to_euler test passed");
    else $display("quaternion_to_euler test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("quaternion_to_euler test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/qte_pkg.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler.sv
test/quaternion_to_euler_check.sv
test/quaternion_to_euler_test.sv
